/* hw/rtl/hmn_pkg.sv */
// ----------------------------------------------------------------------------
// hmn_pkg: shared types and constants of the heightmap normal block
// Payload structs, register reset values, widths of the rounding search.
// ----------------------------------------------------------------------------
`default_nettype none

package hmn_pkg;

    localparam int NORMAL_FRAC_BITS = 14;

    // Result magnitude 0 .. 2^F needs F+1 bits
    localparam int C_W = NORMAL_FRAC_BITS + 1;
    // Sum of squares: 2*255^2 + 4 < 2^17
    localparam int S_W = 17;
    // Running product w*S, w <= 2^(F+1)
    localparam int WS_W = NORMAL_FRAC_BITS + 18;
    // Signed remainder of the rounding search, with headroom
    localparam int REM_W = 2 * NORMAL_FRAC_BITS + 23;
    // Input, square, setup, one stage per result bit, output
    localparam int NUM_STAGES = NORMAL_FRAC_BITS + 5;

    localparam logic [14:0] NORMAL_ONE = 15'(1 << NORMAL_FRAC_BITS);

    localparam logic [12:0] MAP_SIZE_RST   = 13'd512;
    localparam logic [15:0] MAX_HEIGHT_RST = 16'd256;
    localparam logic [14:0] STEEP_THR_RST  = 15'd11469;

    typedef enum logic [1:0] {
        CFG_MAP_SIZE   = 2'd0,
        CFG_MAX_HEIGHT = 2'd1,
        CFG_STEEP_THR  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_z;
        logic [7:0]  center_height;
        logic [7:0]  left_height;
        logic [7:0]  right_height;
        logic [7:0]  down_height;
        logic [7:0]  up_height;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic [14:0]        normal_y;
        logic signed [15:0] normal_z;
        logic               steep;
        logic [23:0]        scaled_height;
    } t_out;

    // Three lanes (x, y, z) of the bitwise rounding search, sharing S
    typedef struct packed {
        logic [S_W-1:0]             s;
        logic [2:0][REM_W-1:0]      rem;
        logic [2:0][WS_W-1:0]       ws;
        logic [2:0][C_W-1:0]        c;
    } t_lanes;

endpackage

`default_nettype wire

/* hw/rtl/hmn_norm_step.sv */
// ----------------------------------------------------------------------------
// hmn_norm_step: one result bit of the normalize-and-round search
// Tries candidate t = c + 2^BIT on all three lanes and keeps it when
// (2t-1)^2 * S <= 4 * v^2 * 4^F, tracked incrementally with shifts and adds.
// ----------------------------------------------------------------------------
`default_nettype none

module hmn_norm_step #(
    parameter int BIT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire hmn_pkg::t_lanes i_lanes,
    output hmn_pkg::t_lanes     o_lanes
);

    localparam int RW = hmn_pkg::REM_W;
    localparam int CW = hmn_pkg::C_W;
    localparam int WW = hmn_pkg::WS_W;

    hmn_pkg::t_lanes r_lanes;
    hmn_pkg::t_lanes n_lanes;

    logic signed [RW-1:0] w_s;
    logic signed [RW-1:0] w_ws   [3];
    logic signed [RW-1:0] w_a    [3];
    logic signed [RW-1:0] w_b    [3];
    logic signed [RW-1:0] w_test [3];
    logic [2:0]           w_take;

    assign w_s = $signed(RW'(i_lanes.s));

    // with w = 2c and k = 2^(BIT+1)-1: (w+k)^2 S = w^2 S + a - b
    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign w_ws[g]   = $signed(RW'(i_lanes.ws[g]));
        assign w_a[g]    = (w_ws[g] <<< (BIT + 2)) + (w_s <<< (2 * BIT + 2));
        assign w_b[g]    = (w_ws[g] <<< 1) + (w_s <<< (BIT + 2)) - w_s;
        assign w_test[g] = $signed(i_lanes.rem[g]) - w_a[g] + w_b[g];
        // drop any further bit once the result has reached one
        assign w_take[g] = !w_test[g][RW-1] && !i_lanes.c[g][CW-1];
    end

    always_comb begin
        n_lanes = i_lanes;
        for (int g = 0; g < 3; g++) begin
            if (w_take[g]) begin
                n_lanes.rem[g] = i_lanes.rem[g] - w_a[g];
                n_lanes.ws[g]  = i_lanes.ws[g] + (WW'(i_lanes.s) << (BIT + 1));
                n_lanes.c[g]   = i_lanes.c[g] | (CW'(1) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

/* hw/rtl/heightmap_normal_and_height.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_and_height: terrain normal, steep flag and scaled height
// Each input transfer carries a sample position and its centre and four cross
// neighbour heights; each output transfer carries the unit normal of
// (left-right, 2, down-up) in Q14, the steep flag and centre*max_height with
// 8 fraction bits. Border positions give the normal (0, 1, 0); positions off
// the map give a zero height. Both channels use valid/ready.
// Throughput: one transfer per cycle while no stall backs up the pipeline; the
// rounding search settles one result bit per stage. The pipeline stages advance
// independently: a stalled receiver holds the output register, and earlier
// stages keep taking input until every stage holds an item. Reset (synchronous,
// active low) empties the pipeline and loads map_size=512, max_height=256,
// steep_threshold=11469. Write the configuration registers only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_normal_and_height (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hmn_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output hmn_pkg::t_out       o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [15:0]    i_cfg_data
);

    localparam int F    = hmn_pkg::NORMAL_FRAC_BITS;
    localparam int NST  = hmn_pkg::NUM_STAGES;
    localparam int LAST = NST - 1;
    localparam int RW   = hmn_pkg::REM_W;
    localparam int SW   = hmn_pkg::S_W;
    localparam logic signed [15:0] ONE_S = $signed(16'(hmn_pkg::NORMAL_ONE));

    // Stage 0: differences and position flags
    typedef struct packed {
        logic signed [8:0] dx;
        logic signed [8:0] dz;
        logic              border;
        logic              on_map;
        logic [7:0]        hc;
    } t_s0;

    // Stage 1: squares and scaled height
    typedef struct packed {
        logic [15:0] sq_x;
        logic [15:0] sq_z;
        logic        neg_x;
        logic        neg_z;
        logic        border;
        logic        on_map;
        logic [23:0] height;
    } t_s1;

    // Sideband that rides along the search stages
    typedef struct packed {
        logic        neg_x;
        logic        neg_z;
        logic        border;
        logic        on_map;
        logic [23:0] height;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [12:0] r_map_size;
    logic [15:0] r_max_height;
    logic [14:0] r_steep_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size   <= hmn_pkg::MAP_SIZE_RST;
            r_max_height <= hmn_pkg::MAX_HEIGHT_RST;
            r_steep_thr  <= hmn_pkg::STEEP_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hmn_pkg::CFG_MAP_SIZE:   r_map_size   <= i_cfg_data[12:0];
                hmn_pkg::CFG_MAX_HEIGHT: r_max_height <= i_cfg_data;
                hmn_pkg::CFG_STEEP_THR:  r_steep_thr  <= i_cfg_data[14:0];
                default: ;  // unused index: ignore the write
            endcase
        end
    end

    // ---------------- stage valids and advance enables ----------------
    // A stage may load when it is empty or some stage downstream of it has
    // room, or the receiver takes the output this cycle.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = i_out_ready || !(&r_vld[LAST:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld[0] <= w_en[0] ? i_in_valid : r_vld[0];
            for (int k = 1; k < NST; k++) begin
                r_vld[k] <= w_en[k] ? r_vld[k-1] : r_vld[k];
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[LAST];

    // ---------------- stage 0: capture the transfer ----------------
    logic [12:0] w_x1;
    logic [12:0] w_z1;
    logic        w_border;
    logic        w_on_map;
    t_s0         r_s0;

    assign w_x1 = {1'b0, i_in_data.pos_x} + 13'd1;
    assign w_z1 = {1'b0, i_in_data.pos_z} + 13'd1;
    // the last row and column count as border so no neighbour falls off the map
    assign w_border = (i_in_data.pos_x == 12'd0) || (i_in_data.pos_z == 12'd0) ||
                      (w_x1 >= r_map_size) || (w_z1 >= r_map_size);
    assign w_on_map = ({1'b0, i_in_data.pos_x} < r_map_size) &&
                      ({1'b0, i_in_data.pos_z} < r_map_size);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0.dx     <= $signed({1'b0, i_in_data.left_height}) -
                           $signed({1'b0, i_in_data.right_height});
            r_s0.dz     <= $signed({1'b0, i_in_data.down_height}) -
                           $signed({1'b0, i_in_data.up_height});
            r_s0.border <= w_border;
            r_s0.on_map <= w_on_map;
            r_s0.hc     <= i_in_data.center_height;
        end
    end

    // ---------------- stage 1: magnitudes, squares, height ----------------
    logic signed [8:0] w_dx_neg;
    logic signed [8:0] w_dz_neg;
    logic [7:0]        w_mag_x;
    logic [7:0]        w_mag_z;
    t_s1               r_s1;

    assign w_dx_neg = -r_s0.dx;
    assign w_dz_neg = -r_s0.dz;
    assign w_mag_x  = r_s0.dx[8] ? w_dx_neg[7:0] : r_s0.dx[7:0];
    assign w_mag_z  = r_s0.dz[8] ? w_dz_neg[7:0] : r_s0.dz[7:0];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1.sq_x   <= 16'(w_mag_x) * 16'(w_mag_x);
            r_s1.sq_z   <= 16'(w_mag_z) * 16'(w_mag_z);
            r_s1.neg_x  <= r_s0.dx[8];
            r_s1.neg_z  <= r_s0.dz[8];
            r_s1.border <= r_s0.border;
            r_s1.on_map <= r_s0.on_map;
            r_s1.height <= 24'(r_s0.hc) * 24'(r_max_height);
        end
    end

    // ---------------- stage 2: set up the rounding search ----------------
    // remainder starts at 4 * v^2 * 4^F for each lane; the y lane has v = 2
    hmn_pkg::t_lanes w_lane [F+2];
    hmn_pkg::t_lanes r_lane_init;
    t_side           r_side [F+2];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_lane_init.s      <= SW'(r_s1.sq_x) + SW'(r_s1.sq_z) + SW'(4);
            r_lane_init.rem[0] <= RW'(r_s1.sq_x) << (2 * F + 2);
            r_lane_init.rem[1] <= RW'(1) << (2 * F + 4);
            r_lane_init.rem[2] <= RW'(r_s1.sq_z) << (2 * F + 2);
            r_lane_init.ws     <= '0;
            r_lane_init.c      <= '0;
            r_side[0].neg_x    <= r_s1.neg_x;
            r_side[0].neg_z    <= r_s1.neg_z;
            r_side[0].border   <= r_s1.border;
            r_side[0].on_map   <= r_s1.on_map;
            r_side[0].height   <= r_s1.height;
        end
    end

    assign w_lane[0] = r_lane_init;

    // ---------------- stages 3 .. F+3: one result bit each, MSB first ----------------
    for (genvar j = 0; j <= F; j++) begin : g_step
        hmn_norm_step #(
            .BIT (F - j)
        ) u_step (
            .i_clk   (i_clk),
            .i_en    (w_en[3+j]),
            .i_lanes (w_lane[j]),
            .o_lanes (w_lane[j+1])
        );

        always_ff @(posedge i_clk) begin
            if (w_en[3+j]) begin
                r_side[j+1] <= r_side[j];
            end
        end
    end

    // ---------------- output stage: signs, border, steep, height ----------------
    hmn_pkg::t_lanes    w_fin;
    t_side              w_fside;
    logic signed [15:0] w_cx;
    logic signed [15:0] w_cz;
    logic [14:0]        w_ny;
    hmn_pkg::t_out      r_out;

    assign w_fin   = w_lane[F+1];
    assign w_fside = r_side[F+1];
    assign w_cx    = $signed(16'(w_fin.c[0]));
    assign w_cz    = $signed(16'(w_fin.c[2]));
    assign w_ny    = w_fside.border ? hmn_pkg::NORMAL_ONE : 15'(w_fin.c[1]);

    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_out.normal_x      <= w_fside.border ? 16'sd0 : (w_fside.neg_x ? -w_cx : w_cx);
            r_out.normal_z      <= w_fside.border ? 16'sd0 : (w_fside.neg_z ? -w_cz : w_cz);
            r_out.normal_y      <= w_ny;
            r_out.steep         <= (w_ny < r_steep_thr);
            r_out.scaled_height <= w_fside.on_map ? w_fside.height : 24'd0;
        end
    end

    assign o_out_data = r_out;

`ifndef NO_ASSERTIONS
    // an accepted transfer lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transfer did not enter stage 0");

    // input is refused only when every stage holds an item and the output stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_ready) |-> ((&r_vld) && !i_out_ready))
        else $error("input refused while the pipeline has room");

    // a straight-up normal has no horizontal part
    a_flat_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.normal_y == hmn_pkg::NORMAL_ONE)) |->
        ((o_out_data.normal_x == 16'sd0) && (o_out_data.normal_z == 16'sd0)))
        else $error("unit y normal with nonzero x or z");

    // every component stays within the unit range
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.normal_x <= ONE_S) && (o_out_data.normal_x >= -ONE_S) &&
                         (o_out_data.normal_z <= ONE_S) && (o_out_data.normal_z >= -ONE_S) &&
                         (o_out_data.normal_y <= hmn_pkg::NORMAL_ONE)))
        else $error("normal component out of unit range");
`endif

endmodule

`default_nettype wire
